/* rtl/core/csfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfc_pkg
// Shared widths, codes, reset values and types of the color and shape
// feature classifier.
// ----------------------------------------------------------------------------
package csfc_pkg;

    localparam int unsigned CNT_W   = 23;   // pixel counts
    localparam int unsigned LUMA_W  = 30;   // luma sum
    localparam int unsigned DIM_W   = 12;   // box width and height
    localparam int unsigned AREA_W  = 2 * DIM_W;
    localparam int unsigned LUMA8_W = 8;    // luma limits
    localparam int unsigned FILL_W  = 10;   // fill floors
    localparam int unsigned OBJK_W  = CNT_W + FILL_W;       // object * 1000
    localparam int unsigned FPROD_W = FILL_W + AREA_W;      // floor * area
    localparam int unsigned WPROD_W = LUMA8_W + CNT_W;      // white * region
    localparam int unsigned BPROD_W = LUMA8_W + 1 + CNT_W;  // (black + 1) * region
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;

    localparam logic [AREA_W-1:0] MIN_BOX_AREA = 24'd100;
    localparam logic [FILL_W-1:0] FILL_FULL    = 10'd1000;

    localparam logic [CNT_W-1:0]   RST_RED_MIN    = 23'd500;
    localparam logic [CNT_W-1:0]   RST_BLUE_MIN   = 23'd500;
    localparam logic [CNT_W-1:0]   RST_YELLOW_MIN = 23'd500;
    localparam logic [LUMA8_W-1:0] RST_WHITE      = 8'd180;
    localparam logic [LUMA8_W-1:0] RST_BLACK      = 8'd55;
    localparam logic [FILL_W-1:0]  RST_CUBE       = 10'd850;
    localparam logic [FILL_W-1:0]  RST_CYLINDER   = 10'd650;
    localparam logic [FILL_W-1:0]  RST_CONE       = 10'd250;

    typedef enum logic [2:0] {
        COLOR_UNKNOWN = 3'd0,
        COLOR_RED     = 3'd1,
        COLOR_BLUE    = 3'd2,
        COLOR_YELLOW  = 3'd3,
        COLOR_WHITE   = 3'd4,
        COLOR_BLACK   = 3'd5
    } t_color;

    typedef enum logic [1:0] {
        SHAPE_UNKNOWN  = 2'd0,
        SHAPE_CUBE     = 2'd1,
        SHAPE_CYLINDER = 2'd2,
        SHAPE_CONE     = 2'd3
    } t_shape;

    typedef enum logic [2:0] {
        REG_RED_MIN    = 3'd0,
        REG_BLUE_MIN   = 3'd1,
        REG_YELLOW_MIN = 3'd2,
        REG_WHITE      = 3'd3,
        REG_BLACK      = 3'd4,
        REG_CUBE       = 3'd5,
        REG_CYLINDER   = 3'd6,
        REG_CONE       = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [CNT_W-1:0]   red_min;
        logic [CNT_W-1:0]   blue_min;
        logic [CNT_W-1:0]   yellow_min;
        logic [LUMA8_W-1:0] white_floor;
        logic [LUMA8_W-1:0] black_ceiling;
        logic [FILL_W-1:0]  cube_floor;
        logic [FILL_W-1:0]  cylinder_floor;
        logic [FILL_W-1:0]  cone_floor;
    } t_cfg;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

endpackage

/* rtl/core/color_shape_feature_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_shape_feature_classifier
// Classifies one object feature record per request into a color class, a
// shape class and a stable flag, with thresholds held in APB registers.
// ----------------------------------------------------------------------------
// Path: an accepted request passes through the stage 1, stage 2 and stage 3
// registers to its result on the master side; the third pipeline register is the output register.
// Throughput: one request per cycle while the master side takes results, set by the three-stage pipeline with
// the multipliers spread over the first two stages.
// Reset: i_rst_n is synchronous and active low; it empties the pipeline and
// returns every threshold register to its default value.
// ----------------------------------------------------------------------------
module color_shape_feature_classifier import csfc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Feature record request.
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // Fields from bit 0 up: red_pixels[22:0], blue_pixels[45:23],
    // yellow_pixels[68:46], region_pixels[91:69], luma_total[121:92],
    // box_width[133:122], box_height[145:134], object_pixels[168:146],
    // zero padding[175:169].
    input  logic [175:0]      s_axis_tdata,
    // Classification result.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // Fields from bit 0 up: color_class[2:0], shape_class[4:3], stable[5],
    // zero padding[7:6].
    output logic [7:0]        m_axis_tdata,
    // Threshold register port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg      cfg;
    t_stage_en en;
    t_color    color;
    t_shape    shape;
    logic      stable;

    // Each stage holds a valid bit. A stage may load when it is empty or
    // when the stage after it is moving, so bubbles are squeezed out and a
    // new request is taken even while a finished result waits downstream.
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic rdy1;
    logic rdy2;
    logic rdy3;

    assign rdy3 = !r_v3 || m_axis_tready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = r_v3;

    assign en.s1 = s_axis_tvalid && rdy1;
    assign en.s2 = r_v1 && rdy2;
    assign en.s3 = r_v2 && rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    csfc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The request payload is unpacked straight into the first stage.
    csfc_datapath u_datapath (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_cfg    (cfg),
        .i_red    (s_axis_tdata[22:0]),
        .i_blue   (s_axis_tdata[45:23]),
        .i_yellow (s_axis_tdata[68:46]),
        .i_region (s_axis_tdata[91:69]),
        .i_luma   (s_axis_tdata[121:92]),
        .i_width  (s_axis_tdata[133:122]),
        .i_height (s_axis_tdata[145:134]),
        .i_object (s_axis_tdata[168:146]),
        .o_color  (color),
        .o_shape  (shape),
        .o_stable (stable)
    );

    assign m_axis_tdata = {2'b00, stable, shape, color};

endmodule

/* rtl/core/csfc_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfc_cfg
// APB register file holding the classification thresholds.
// ----------------------------------------------------------------------------
module csfc_cfg import csfc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr     = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red_min        <= RST_RED_MIN;
            r_cfg.blue_min       <= RST_BLUE_MIN;
            r_cfg.yellow_min     <= RST_YELLOW_MIN;
            r_cfg.white_floor    <= RST_WHITE;
            r_cfg.black_ceiling  <= RST_BLACK;
            r_cfg.cube_floor     <= RST_CUBE;
            r_cfg.cylinder_floor <= RST_CYLINDER;
            r_cfg.cone_floor     <= RST_CONE;
        end else if (wr) begin
            unique case (idx)
                REG_RED_MIN:    r_cfg.red_min        <= pwdata[CNT_W-1:0];
                REG_BLUE_MIN:   r_cfg.blue_min       <= pwdata[CNT_W-1:0];
                REG_YELLOW_MIN: r_cfg.yellow_min     <= pwdata[CNT_W-1:0];
                REG_WHITE:      r_cfg.white_floor    <= pwdata[LUMA8_W-1:0];
                REG_BLACK:      r_cfg.black_ceiling  <= pwdata[LUMA8_W-1:0];
                REG_CUBE:       r_cfg.cube_floor     <= pwdata[FILL_W-1:0];
                REG_CYLINDER:   r_cfg.cylinder_floor <= pwdata[FILL_W-1:0];
                REG_CONE:       r_cfg.cone_floor     <= pwdata[FILL_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_RED_MIN:    prdata = DATA_W'(r_cfg.red_min);
            REG_BLUE_MIN:   prdata = DATA_W'(r_cfg.blue_min);
            REG_YELLOW_MIN: prdata = DATA_W'(r_cfg.yellow_min);
            REG_WHITE:      prdata = DATA_W'(r_cfg.white_floor);
            REG_BLACK:      prdata = DATA_W'(r_cfg.black_ceiling);
            REG_CUBE:       prdata = DATA_W'(r_cfg.cube_floor);
            REG_CYLINDER:   prdata = DATA_W'(r_cfg.cylinder_floor);
            REG_CONE:       prdata = DATA_W'(r_cfg.cone_floor);
        endcase
    end

endmodule

/* rtl/core/csfc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfc_datapath
// Three-stage classification datapath; each stage loads on its enable.
// ----------------------------------------------------------------------------
module csfc_datapath import csfc_pkg::*; (
    input  logic              i_clk,
    input  t_stage_en         i_en,
    input  t_cfg              i_cfg,
    input  logic [CNT_W-1:0]  i_red,
    input  logic [CNT_W-1:0]  i_blue,
    input  logic [CNT_W-1:0]  i_yellow,
    input  logic [CNT_W-1:0]  i_region,
    input  logic [LUMA_W-1:0] i_luma,
    input  logic [DIM_W-1:0]  i_width,
    input  logic [DIM_W-1:0]  i_height,
    input  logic [CNT_W-1:0]  i_object,
    output t_color            o_color,
    output t_shape            o_shape,
    output logic              o_stable
);

    // Stage 1: color pick, products against region and box.
    logic [CNT_W-1:0]   top;
    logic [CNT_W-1:0]   need;
    t_color             pick;
    t_color             r1_pick;
    logic               r1_pick_ok;
    logic               r1_region_nz;
    logic [LUMA_W-1:0]  r1_luma;
    logic [WPROD_W-1:0] r1_wprod;
    logic [BPROD_W-1:0] r1_bprod;
    logic [AREA_W-1:0]  r1_area;
    logic [OBJK_W-1:0]  r1_objk;
    logic               r1_obj_nz;

    always_comb begin
        top  = i_red;
        need = i_cfg.red_min;
        pick = COLOR_RED;
        if (i_blue > top) begin
            top  = i_blue;
            need = i_cfg.blue_min;
            pick = COLOR_BLUE;
        end
        if (i_yellow > top) begin
            top  = i_yellow;
            need = i_cfg.yellow_min;
            pick = COLOR_YELLOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_pick      <= pick;
            r1_pick_ok   <= (top >= need);
            r1_region_nz <= (i_region != '0);
            r1_luma      <= i_luma;
            r1_wprod     <= WPROD_W'(i_cfg.white_floor) * WPROD_W'(i_region);
            r1_bprod     <= BPROD_W'({1'b0, i_cfg.black_ceiling} + 9'd1)
                            * BPROD_W'(i_region);
            r1_area      <= AREA_W'(i_width) * AREA_W'(i_height);
            r1_objk      <= OBJK_W'(i_object) * OBJK_W'(FILL_FULL);
            r1_obj_nz    <= (i_object != '0);
        end
    end

    // Stage 2: final color; the truncated mean compares as luma against
    // white * region or (black + 1) * region, so no division is needed.
    t_color             color2;
    t_color             r2_color;
    logic               r2_shape_ok;
    logic [OBJK_W-1:0]  r2_objk;
    logic [FPROD_W-1:0] r2_cube_prod;
    logic [FPROD_W-1:0] r2_cyl_prod;
    logic [FPROD_W-1:0] r2_cone_prod;

    always_comb begin
        priority if (r1_pick_ok) begin
            color2 = r1_pick;
        end else if (!r1_region_nz) begin
            color2 = COLOR_UNKNOWN;
        end else if (WPROD_W'(r1_luma) >= r1_wprod) begin
            color2 = COLOR_WHITE;
        end else if (BPROD_W'(r1_luma) < r1_bprod) begin
            color2 = COLOR_BLACK;
        end else begin
            color2 = COLOR_UNKNOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r2_color     <= color2;
            r2_shape_ok  <= r1_obj_nz && (r1_area >= MIN_BOX_AREA);
            r2_objk      <= r1_objk;
            r2_cube_prod <= FPROD_W'(i_cfg.cube_floor) * FPROD_W'(r1_area);
            r2_cyl_prod  <= FPROD_W'(i_cfg.cylinder_floor) * FPROD_W'(r1_area);
            r2_cone_prod <= FPROD_W'(i_cfg.cone_floor) * FPROD_W'(r1_area);
        end
    end

    // Stage 3: fill >= floor holds exactly when object*1000 >= floor*area,
    // given the floor does not exceed the 1000 cap.
    logic   cube_hit;
    logic   cyl_hit;
    logic   cone_hit;
    t_shape shape3;
    t_color r3_color;
    t_shape r3_shape;
    logic   r3_stable;

    assign cube_hit = (i_cfg.cube_floor <= FILL_FULL)
                      && (FPROD_W'(r2_objk) >= r2_cube_prod);
    assign cyl_hit  = (i_cfg.cylinder_floor <= FILL_FULL)
                      && (FPROD_W'(r2_objk) >= r2_cyl_prod);
    assign cone_hit = (i_cfg.cone_floor <= FILL_FULL)
                      && (FPROD_W'(r2_objk) >= r2_cone_prod);

    always_comb begin
        priority if (!r2_shape_ok) begin
            shape3 = SHAPE_UNKNOWN;
        end else if (cube_hit) begin
            shape3 = SHAPE_CUBE;
        end else if (cyl_hit) begin
            shape3 = SHAPE_CYLINDER;
        end else if (cone_hit) begin
            shape3 = SHAPE_CONE;
        end else begin
            shape3 = SHAPE_UNKNOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r3_color  <= r2_color;
            r3_shape  <= shape3;
            r3_stable <= (r2_color != COLOR_UNKNOWN) && (shape3 != SHAPE_UNKNOWN);
        end
    end

    assign o_color  = r3_color;
    assign o_shape  = r3_shape;
    assign o_stable = r3_stable;

endmodule
